>>> rtl/core/text_terminal_screen_controller_unit_macros.svh
// Assertion macros used by the terminal controller checker.
`ifndef TEXT_TERMINAL_SCREEN_CONTROLLER_UNIT_MACROS_SVH
`define TEXT_TERMINAL_SCREEN_CONTROLLER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TTSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define TTSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ttsc_pkg.sv
// Shared constants, types and functions of the text terminal controller.
`timescale 1ns / 1ps

package ttsc_pkg;

   // Default screen geometry
   localparam int SCREEN_ROWS_DEF = 24;
   localparam int SCREEN_COLS_DEF = 40;

   // Word field widths
   localparam int FUNC_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int ROW_FW   = 5;
   localparam int COL_FW   = 6;
   localparam int SHOWN_W  = 7;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_GLYPH = 1'd1;
   localparam logic [7:0] BLINK_PERIOD_RESET = 8'd10;
   localparam logic [6:0] CURSOR_GLYPH_RESET = 7'd64;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_QMARK = 8'd63;
   localparam logic [CHAR_W-1:0] CH_FIRST_SHOWN = 8'd32;
   localparam logic [CHAR_W-1:0] CH_LAST_SHOWN  = 8'd127;

   // Command codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // Control flags of one put-character step
   typedef struct packed {
      logic write_cell;   // a cell is written
      logic blank_write;  // the written value is a space
      logic scroll;       // the screen moves up one row
   } put_ctl_type;

   // Map a stored code to the displayed code
   function automatic logic [SHOWN_W-1:0] map_shown(input logic [CHAR_W-1:0] code);
      if (code < CH_FIRST_SHOWN || code > CH_LAST_SHOWN) begin
         return CH_QMARK[SHOWN_W-1:0];
      end
      return code[SHOWN_W-1:0];
   endfunction

endpackage

>>> rtl/core/ttsc_channels.sv
// Command and result channel interfaces of the text terminal controller.
`timescale 1ns / 1ps

interface ttsc_req_if;
   logic                             valid;
   logic                             ready;
   logic [ttsc_pkg::FUNC_W-1:0]      func;
   logic [ttsc_pkg::CHAR_W-1:0]      char_code;
   logic [ttsc_pkg::ROW_FW-1:0]      read_row;
   logic [ttsc_pkg::COL_FW-1:0]      read_col;

   modport source (output valid, func, char_code, read_row, read_col, input ready);
   modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

interface ttsc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ttsc_pkg::SHOWN_W-1:0]     shown_char;
   logic                             cell_is_cursor;
   logic [ttsc_pkg::ROW_FW-1:0]      cursor_row;
   logic [ttsc_pkg::COL_FW-1:0]      cursor_col;
   logic                             cursor_shown;
   logic                             did_scroll;

   modport source (output valid, shown_char, cell_is_cursor, cursor_row, cursor_col,
                   cursor_shown, did_scroll, input ready);
   modport sink   (input valid, shown_char, cell_is_cursor, cursor_row, cursor_col,
                   cursor_shown, did_scroll, output ready);
endinterface

>>> rtl/core/ttsc_put_step.sv
// Cursor movement and cell write decision for one put-character command.
`timescale 1ns / 1ps

module ttsc_put_step #(
   parameter int SCREEN_ROWS = ttsc_pkg::SCREEN_ROWS_DEF,
   parameter int SCREEN_COLS = ttsc_pkg::SCREEN_COLS_DEF
) (
   input  logic [$clog2(SCREEN_ROWS)-1:0] row,
   input  logic [$clog2(SCREEN_COLS)-1:0] col,
   input  logic [ttsc_pkg::CHAR_W-1:0]    code,
   output logic [$clog2(SCREEN_ROWS)-1:0] next_row,
   output logic [$clog2(SCREEN_COLS)-1:0] next_col,
   output logic [$clog2(SCREEN_COLS)-1:0] write_col,
   output ttsc_pkg::put_ctl_type          ctl
);

   localparam int RW = $clog2(SCREEN_ROWS);
   localparam int CW = $clog2(SCREEN_COLS);
   localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

   logic [RW-1:0] down_row;
   logic          down_scroll;

   // Step to the next line, staying on the last one when the screen scrolls
   always_comb begin
      down_scroll = (row == LAST_ROW);
      down_row    = down_scroll ? row : row + RW'(1);
   end

   // Decode the byte
   always_comb begin
      next_row  = row;
      next_col  = col;
      write_col = col;
      ctl       = '0;
      case (code)
         ttsc_pkg::CH_NL: begin
            next_col   = '0;
            next_row   = down_row;
            ctl.scroll = down_scroll;
         end
         ttsc_pkg::CH_CR: begin
            next_col = '0;
         end
         ttsc_pkg::CH_BS: begin
            write_col       = (col != '0) ? col - CW'(1) : '0;
            next_col        = write_col;
            ctl.write_cell  = 1'b1;
            ctl.blank_write = 1'b1;
         end
         default: begin
            ctl.write_cell = 1'b1;
            if (col == LAST_COL) begin
               next_col   = '0;
               next_row   = down_row;
               ctl.scroll = down_scroll;
            end else begin
               next_col = col + CW'(1);
            end
         end
      endcase
   end

endmodule

>>> rtl/core/text_terminal_screen_controller_unit.sv
// Text terminal screen controller top level: cell memory, cursor and blink control.
`timescale 1ns / 1ps

// Character-cell terminal of SCREEN_ROWS x SCREEN_COLS cells held in one
// single-port-write, registered-read cell memory. Rows are kept as a ring:
// a scroll moves the top-row pointer and marks the row that enters at the
// bottom as blank; clear marks every row blank and homes the cursor. A blank
// row reads as spaces and is swept with spaces the first time a character is
// stored in it. There is no clearing pass after reset. From acceptance to
// result: tick, clear, newline, return, and a put or backspace on a row
// already written have their result in the cycle after acceptance; a read
// passes through the registered memory read and the S_READ state; a put of
// a character into a blank row sweeps it (one cell per cycle, through the
// memory's write port). One word is in work at a time; a new command word is
// taken while a finished result waits, provided the result side takes it in
// the same cycle. Configuration writes take effect on the next cycle.
module text_terminal_screen_controller_unit #(
   parameter int SCREEN_ROWS = ttsc_pkg::SCREEN_ROWS_DEF,
   parameter int SCREEN_COLS = ttsc_pkg::SCREEN_COLS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   ttsc_req_if.sink                           req_chan,
   ttsc_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_en,
   input  logic [ttsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ttsc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int RW     = $clog2(SCREEN_ROWS);
   localparam int RW1    = RW + 1;
   localparam int CW     = $clog2(SCREEN_COLS);
   localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int ROW_FW = ttsc_pkg::ROW_FW;
   localparam int COL_FW = ttsc_pkg::COL_FW;
   localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);
   localparam logic [ttsc_pkg::SHOWN_W-1:0] SPACE7 =
      ttsc_pkg::CH_SPACE[ttsc_pkg::SHOWN_W-1:0];

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_FILL = 3'b100
   } state_type;

   // Ring position of a logical row
   function automatic logic [RW-1:0] wrap_row(input logic [RW-1:0] a,
                                              input logic [RW-1:0] b);
      logic [RW1-1:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= RW1'(SCREEN_ROWS)) begin
         sum = sum - RW1'(SCREEN_ROWS);
      end
      return sum[RW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                               input logic [CW-1:0] pcol);
      return AW'(prow) * AW'(SCREEN_COLS) + AW'(pcol);
   endfunction

   // Control and cursor state
   state_type                  state_ff, state_in;
   logic [RW-1:0]              top_ff, top_in;
   logic [SCREEN_ROWS-1:0]     blank_ff, blank_in;
   logic [RW-1:0]              row_ff, row_in;
   logic [CW-1:0]              col_ff, col_in;
   logic                       lit_ff, lit_in;
   logic [7:0]                 cnt_ff, cnt_in;
   logic [7:0]                 period_ff;
   logic [6:0]                 glyph_ff;

   // Cell memory
   logic [ttsc_pkg::CHAR_W-1:0] cell_mem_ff [DEPTH];
   logic [ttsc_pkg::CHAR_W-1:0] rd_data_ff;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [ttsc_pkg::CHAR_W-1:0] mem_wdata;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;

   // Pending read
   logic rd_hit_ff, rd_overlay_ff, rd_blank_ff;
   logic rd_hit, rd_overlay;
   logic [RW-1:0] rd_row_t, rd_phys;
   logic [CW-1:0] rd_col_t;

   // Row sweep
   logic [RW-1:0]               fill_row_ff, fill_row_in;
   logic [CW-1:0]               fill_col_ff, fill_col_in;
   logic [CW-1:0]               tgt_col_ff, tgt_col_in;
   logic [ttsc_pkg::CHAR_W-1:0] fill_char_ff, fill_char_in;
   logic                        fill_scroll_ff, fill_scroll_in;

   // Result word
   logic                        rsp_valid_ff;
   logic [ttsc_pkg::SHOWN_W-1:0] rsp_char_ff;
   logic                        rsp_is_cur_ff;
   logic [ROW_FW-1:0]           rsp_row_ff;
   logic [COL_FW-1:0]           rsp_col_ff;
   logic                        rsp_shown_ff;
   logic                        rsp_scroll_ff;
   logic                        finish;
   logic [ttsc_pkg::SHOWN_W-1:0] fin_char;
   logic                        fin_cur;
   logic                        fin_scroll;

   // Put-character decode
   logic [RW-1:0]               put_row;
   logic [CW-1:0]               put_col;
   logic [CW-1:0]               put_wcol;
   ttsc_pkg::put_ctl_type       put_ctl;
   logic [RW-1:0]               cur_phys;
   logic                        accept;
   logic [7:0]                  cnt_step;

   ttsc_put_step #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .SCREEN_COLS (SCREEN_COLS)
   ) u_put_step (
      .row       (row_ff),
      .col       (col_ff),
      .code      (req_chan.char_code),
      .next_row  (put_row),
      .next_col  (put_col),
      .write_col (put_wcol),
      .ctl       (put_ctl)
   );

   // Take a word only when idle and the result register will be free
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign cur_phys       = wrap_row(top_ff, row_ff);
   assign cnt_step       = cnt_ff + 8'd1;

   // Locate the read cell
   always_comb begin
      rd_row_t   = RW'(req_chan.read_row);
      rd_col_t   = CW'(req_chan.read_col);
      rd_hit     = (int'(req_chan.read_row) < SCREEN_ROWS) &&
                   (int'(req_chan.read_col) < SCREEN_COLS);
      rd_phys    = wrap_row(top_ff, rd_row_t);
      rd_overlay = lit_ff && (rd_row_t == row_ff) && (rd_col_t == col_ff);
      rd_addr    = rd_hit ? cell_addr(rd_phys, rd_col_t) : '0;
   end

   // Command sequencing
   always_comb begin
      state_in       = state_ff;
      top_in         = top_ff;
      blank_in       = blank_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      lit_in         = lit_ff;
      cnt_in         = cnt_ff;
      fill_row_in    = fill_row_ff;
      fill_col_in    = fill_col_ff;
      tgt_col_in     = tgt_col_ff;
      fill_char_in   = fill_char_ff;
      fill_scroll_in = fill_scroll_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = ttsc_pkg::CH_SPACE;
      rd_en          = 1'b0;
      finish         = 1'b0;
      fin_char       = SPACE7;
      fin_cur        = 1'b0;
      fin_scroll     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (ttsc_pkg::func_type'(req_chan.func))
                  ttsc_pkg::FUNC_PUT: begin
                     lit_in = 1'b0;
                     row_in = put_row;
                     col_in = put_col;
                     if (put_ctl.write_cell && !blank_ff[cur_phys]) begin
                        // Row already holds text: write the cell now
                        mem_we     = 1'b1;
                        mem_waddr  = cell_addr(cur_phys, put_wcol);
                        mem_wdata  = put_ctl.blank_write ? ttsc_pkg::CH_SPACE
                                                         : req_chan.char_code;
                        finish     = 1'b1;
                        fin_scroll = put_ctl.scroll;
                     end else if (put_ctl.write_cell && !put_ctl.blank_write) begin
                        // Blank row: sweep it, dropping the byte in on the way
                        state_in           = S_FILL;
                        fill_row_in        = cur_phys;
                        fill_col_in        = '0;
                        tgt_col_in         = put_wcol;
                        fill_char_in       = req_chan.char_code;
                        fill_scroll_in     = put_ctl.scroll;
                        blank_in[cur_phys] = 1'b0;
                     end else begin
                        finish     = 1'b1;
                        fin_scroll = put_ctl.scroll;
                     end
                     if (put_ctl.scroll) begin
                        // Old top row becomes the blank bottom row
                        top_in           = wrap_row(top_ff, RW'(1));
                        blank_in[top_ff] = 1'b1;
                     end
                  end
                  ttsc_pkg::FUNC_TICK: begin
                     finish = 1'b1;
                     if (cnt_step >= period_ff) begin
                        cnt_in = '0;
                        lit_in = !lit_ff;
                     end else begin
                        cnt_in = cnt_step;
                     end
                  end
                  ttsc_pkg::FUNC_READ: begin
                     rd_en    = 1'b1;
                     state_in = S_READ;
                  end
                  ttsc_pkg::FUNC_CLEAR: begin
                     finish   = 1'b1;
                     blank_in = '1;
                     top_in   = '0;
                     row_in   = '0;
                     col_in   = '0;
                     lit_in   = 1'b0;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            // Overlay the cursor and map the stored code
            finish   = 1'b1;
            state_in = S_IDLE;
            fin_cur  = rd_hit_ff && rd_overlay_ff;
            if (!rd_hit_ff) begin
               fin_char = SPACE7;
            end else if (rd_overlay_ff) begin
               fin_char = ttsc_pkg::map_shown({1'b0, glyph_ff});
            end else if (rd_blank_ff) begin
               fin_char = SPACE7;
            end else begin
               fin_char = ttsc_pkg::map_shown(rd_data_ff);
            end
         end
         S_FILL: begin
            mem_we      = 1'b1;
            mem_waddr   = cell_addr(fill_row_ff, fill_col_ff);
            mem_wdata   = (fill_col_ff == tgt_col_ff) ? fill_char_ff : ttsc_pkg::CH_SPACE;
            fill_col_in = fill_col_ff + CW'(1);
            if (fill_col_ff == LAST_COL) begin
               finish     = 1'b1;
               fin_scroll = fill_scroll_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         top_ff   <= '0;
         blank_ff <= '1;
         row_ff   <= '0;
         col_ff   <= '0;
         lit_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         blank_ff <= blank_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         lit_ff   <= lit_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= ttsc_pkg::BLINK_PERIOD_RESET;
         glyph_ff  <= ttsc_pkg::CURSOR_GLYPH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ttsc_pkg::CSR_BLINK_PERIOD: period_ff <= csr_data;
            ttsc_pkg::CSR_CURSOR_GLYPH: glyph_ff  <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Sweep and read bookkeeping
   always_ff @(posedge clock) begin
      fill_row_ff    <= fill_row_in;
      fill_col_ff    <= fill_col_in;
      tgt_col_ff     <= tgt_col_in;
      fill_char_ff   <= fill_char_in;
      fill_scroll_ff <= fill_scroll_in;
      if (rd_en) begin
         rd_hit_ff     <= rd_hit;
         rd_overlay_ff <= rd_overlay;
         rd_blank_ff   <= rd_hit ? blank_ff[rd_phys] : 1'b1;
      end
   end

   // Cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= cell_mem_ff[rd_addr];
      end
   end

   // Result register: load on finish, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_char_ff   <= fin_char;
         rsp_is_cur_ff <= fin_cur;
         rsp_row_ff    <= ROW_FW'(row_in);
         rsp_col_ff    <= COL_FW'(col_in);
         rsp_shown_ff  <= lit_in;
         rsp_scroll_ff <= fin_scroll;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.shown_char     = rsp_char_ff;
   assign rsp_chan.cell_is_cursor = rsp_is_cur_ff;
   assign rsp_chan.cursor_row     = rsp_row_ff;
   assign rsp_chan.cursor_col     = rsp_col_ff;
   assign rsp_chan.cursor_shown   = rsp_shown_ff;
   assign rsp_chan.did_scroll     = rsp_scroll_ff;

endmodule

>>> rtl/core/ttsc_checker.sv
// Port-level checks of the text terminal controller, bound to the top level.
`timescale 1ns / 1ps
`include "text_terminal_screen_controller_unit_macros.svh"

module ttsc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ttsc_pkg::SHOWN_W-1:0]      rsp_shown_char,
   input logic                              rsp_cell_is_cursor,
   input logic [ttsc_pkg::ROW_FW-1:0]       rsp_cursor_row,
   input logic [ttsc_pkg::COL_FW-1:0]       rsp_cursor_col,
   input logic                              rsp_cursor_shown,
   input logic                              rsp_did_scroll
);

   logic [ttsc_pkg::SHOWN_W + ttsc_pkg::ROW_FW + ttsc_pkg::COL_FW + 2:0] rsp_word;

   assign rsp_word = {rsp_shown_char, rsp_cell_is_cursor, rsp_cursor_row, rsp_cursor_col,
                      rsp_cursor_shown, rsp_did_scroll};

   // Hold a stalled result word
   `TTSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")
   `TTSC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word), "result word changed while stalled")

   // A command word is taken only when its result has room
   `TTSC_ASSERT(a_accept_room, clock, reset, !(req_valid && req_ready) || !rsp_valid || rsp_ready, "command taken while result register full")

   // The cursor glyph only shows while the cursor is lit
   `TTSC_ASSERT(a_cursor_lit, clock, reset, !(rsp_valid && rsp_cell_is_cursor) || rsp_cursor_shown, "cursor cell reported while cursor hidden")

   // Reset empties the result register
   `TTSC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result word present after reset")

endmodule

bind text_terminal_screen_controller_unit ttsc_checker u_ttsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_shown_char     (rsp_chan.shown_char),
   .rsp_cell_is_cursor (rsp_chan.cell_is_cursor),
   .rsp_cursor_row     (rsp_chan.cursor_row),
   .rsp_cursor_col     (rsp_chan.cursor_col),
   .rsp_cursor_shown   (rsp_chan.cursor_shown),
   .rsp_did_scroll     (rsp_chan.did_scroll)
);

>>> tb/ttsc_screen_monitor.sv
// Screen monitor: mirrors the terminal state, predicts each result word and compares it.
`timescale 1ns / 1ps

module ttsc_screen_monitor
   import ttsc_pkg::*;
#(
   parameter int ROWS = SCREEN_ROWS_DEF,
   parameter int COLS = SCREEN_COLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ttsc_req_if                    req_chan,
   ttsc_rsp_if                    rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SHOWN_W-1:0] shown_char;
      logic               cell_is_cursor;
      logic [ROW_FW-1:0]  cursor_row;
      logic [COL_FW-1:0]  cursor_col;
      logic               cursor_shown;
      logic               did_scroll;
   } screen_word_t;

   // Mirror of the terminal state and its registers
   logic [CHAR_W-1:0] cells [ROWS][COLS];
   int                cur_row;
   int                cur_col;
   logic              cursor_lit;
   logic [7:0]        blink_count;
   logic [7:0]        blink_period;
   logic [6:0]        cursor_glyph;
   screen_word_t      expected_words[$];
   int                words_checked;

   // Out-of-range codes show as a question mark
   function automatic logic [SHOWN_W-1:0] display_code(input logic [CHAR_W-1:0] code);
      if (code < CH_FIRST_SHOWN || code > CH_LAST_SHOWN) begin
         return CH_QMARK[SHOWN_W-1:0];
      end
      return code[SHOWN_W-1:0];
   endfunction

   function automatic void blank_screen();
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            cells[r][c] = CH_SPACE;
         end
      end
   endfunction

   // Step down one row; scroll the screen up when past the last row
   function automatic logic next_row();
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int r = 1; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               cells[r-1][c] = cells[r][c];
            end
         end
         for (int c = 0; c < COLS; c++) begin
            cells[ROWS-1][c] = CH_SPACE;
         end
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one command word to the mirror and build its result word
   function automatic screen_word_t predict_word(input func_type op,
                                                 input logic [CHAR_W-1:0] code,
                                                 input logic [ROW_FW-1:0] rrow,
                                                 input logic [COL_FW-1:0] rcol);
      screen_word_t w;
      logic         scrolled;
      w = '0;
      w.shown_char = CH_SPACE[SHOWN_W-1:0];
      scrolled = 1'b0;
      case (op)
         FUNC_PUT: begin
            cursor_lit = 1'b0;
            if (code == CH_NL) begin
               cur_col = 0;
               scrolled = next_row();
            end else if (code == CH_CR) begin
               cur_col = 0;
            end else if (code == CH_BS) begin
               if (cur_col > 0) begin
                  cur_col--;
               end
               cells[cur_row][cur_col] = CH_SPACE;
            end else begin
               cells[cur_row][cur_col] = code;
               cur_col++;
               if (cur_col >= COLS) begin
                  cur_col = 0;
                  scrolled = next_row();
               end
            end
         end
         FUNC_TICK: begin
            blink_count = blink_count + 8'd1;
            if (blink_count >= blink_period) begin
               blink_count = 8'd0;
               cursor_lit = !cursor_lit;
            end
         end
         FUNC_READ: begin
            if (int'(rrow) < ROWS && int'(rcol) < COLS) begin
               if (cursor_lit && int'(rrow) == cur_row && int'(rcol) == cur_col) begin
                  w.shown_char = display_code({1'b0, cursor_glyph});
                  w.cell_is_cursor = 1'b1;
               end else begin
                  w.shown_char = display_code(cells[rrow][rcol]);
               end
            end
         end
         default: begin
            // clear keeps the blink counter
            blank_screen();
            cur_row = 0;
            cur_col = 0;
            cursor_lit = 1'b0;
         end
      endcase
      w.cursor_row = cur_row[ROW_FW-1:0];
      w.cursor_col = cur_col[COL_FW-1:0];
      w.cursor_shown = cursor_lit;
      w.did_scroll = scrolled;
      return w;
   endfunction

   function automatic void note_failure(input string what, input screen_word_t want,
                                        input screen_word_t got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t word %0d %s: expected char %0d cur %0b row %0d col %0d lit %0b scr %0b,",
                  $realtime, words_checked, what, want.shown_char, want.cell_is_cursor,
                  want.cursor_row, want.cursor_col, want.cursor_shown, want.did_scroll);
         $display("   got char %0d cur %0b row %0d col %0d lit %0b scr %0b",
                  got.shown_char, got.cell_is_cursor, got.cursor_row, got.cursor_col,
                  got.cursor_shown, got.did_scroll);
      end
   endfunction

   // Check result words first, then queue the prediction of a newly taken word
   always @(posedge clock) begin
      screen_word_t got;
      screen_word_t want;
      if (reset) begin
         blank_screen();
         cur_row = 0;
         cur_col = 0;
         cursor_lit = 1'b0;
         blink_count = 8'd0;
         blink_period = BLINK_PERIOD_RESET;
         cursor_glyph = CURSOR_GLYPH_RESET;
         expected_words.delete();
         words_checked = 0;
         fail_count = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.shown_char = rsp_chan.shown_char;
            got.cell_is_cursor = rsp_chan.cell_is_cursor;
            got.cursor_row = rsp_chan.cursor_row;
            got.cursor_col = rsp_chan.cursor_col;
            got.cursor_shown = rsp_chan.cursor_shown;
            got.did_scroll = rsp_chan.did_scroll;
            if (expected_words.size() == 0) begin
               note_failure("unexpected", '0, got);
            end else begin
               want = expected_words.pop_front();
               if (got.shown_char !== want.shown_char ||
                   got.cell_is_cursor !== want.cell_is_cursor ||
                   got.cursor_row !== want.cursor_row ||
                   got.cursor_col !== want.cursor_col ||
                   got.cursor_shown !== want.cursor_shown ||
                   got.did_scroll !== want.did_scroll) begin
                  note_failure("mismatch", want, got);
               end
            end
            words_checked++;
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_words.push_back(predict_word(func_type'(req_chan.func), req_chan.char_code,
                                                  req_chan.read_row, req_chan.read_col));
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_BLINK_PERIOD: blink_period = csr_data;
               CSR_CURSOR_GLYPH: cursor_glyph = csr_data[6:0];
            endcase
         end
      end
      pending = expected_words.size();
   end

endmodule

>>> tb/tb_text_terminal_screen_controller_unit.sv
// Testbench top: clock, reset, command stimulus, register phases and the final verdict.
`timescale 1ns / 1ps

module tb_text_terminal_screen_controller_unit;
   import ttsc_pkg::*;

   localparam int ROWS = SCREEN_ROWS_DEF;
   localparam int COLS = SCREEN_COLS_DEF;
   localparam int RANDOM_WORDS = 950;
   localparam int PHASES = 5;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     fail_count;
   int                     pending;
   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;
   int                     words_sent = 0;
   logic [ROW_FW-1:0]      seen_row = '0;
   logic [COL_FW-1:0]      seen_col = '0;

   ttsc_req_if req_if();
   ttsc_rsp_if rsp_if();

   text_terminal_screen_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   ttsc_screen_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stall the result side at random
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Track the last cursor position reported, to aim reads at the cursor
   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) begin
         seen_row <= rsp_if.cursor_row;
         seen_col <= rsp_if.cursor_col;
      end
   end

   // Offer one command word and hold it until taken
   task automatic send_word(input func_type op, input logic [CHAR_W-1:0] code,
                            input logic [ROW_FW-1:0] rrow, input logic [COL_FW-1:0] rcol);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.func = op;
      req_if.char_code = code;
      req_if.read_row = rrow;
      req_if.read_col = rcol;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] code);
      send_word(FUNC_PUT, code, 5'($urandom_range(31)), 6'($urandom_range(63)));
   endtask

   task automatic tick();
      send_word(FUNC_TICK, 8'($urandom_range(255)), 5'($urandom_range(31)),
                6'($urandom_range(63)));
   endtask

   task automatic read_cell(input logic [ROW_FW-1:0] rrow, input logic [COL_FW-1:0] rcol);
      send_word(FUNC_READ, 8'($urandom_range(255)), rrow, rcol);
   endtask

   task automatic clear_screen();
      send_word(FUNC_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                6'($urandom_range(63)));
   endtask

   // Drop valid and hold until every result word is back and the block is quiet
   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (COLS + 4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // One random burst: text lines, newline runs, blink ticks, reads or a clear
   task automatic random_burst();
      int               kind;
      int               len;
      logic [CHAR_W-1:0] code;
      kind = $urandom_range(99);
      if (kind < 35) begin
         len = $urandom_range(1, 45);
         repeat (len) begin
            case ($urandom_range(29))
               0:       code = 8'($urandom_range(255));
               1:       code = CH_BS;
               2:       code = CH_CR;
               default: code = 8'($urandom_range(32, 126));
            endcase
            put_char(code);
         end
         if ($urandom_range(1) == 1) put_char(CH_NL);
      end else if (kind < 47) begin
         len = $urandom_range(1, 30);
         repeat (len) put_char(CH_NL);
      end else if (kind < 67) begin
         len = $urandom_range(1, 6);
         repeat (len) tick();
         read_cell(seen_row, seen_col);
      end else if (kind < 97) begin
         len = $urandom_range(1, 8);
         repeat (len) begin
            if ($urandom_range(9) == 0) begin
               read_cell(5'($urandom_range(31)), 6'($urandom_range(63)));
            end else if ($urandom_range(2) == 0) begin
               read_cell(seen_row, seen_col);
            end else begin
               read_cell(5'($urandom_range(ROWS - 1)), 6'($urandom_range(COLS - 1)));
            end
         end
      end else begin
         clear_screen();
      end
   endtask

   initial begin
      int   phase;
      int   phase_start;
      logic paused;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.func = FUNC_PUT;
      req_if.char_code = '0;
      req_if.read_row = '0;
      req_if.read_col = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: code extremes, controls at column 0, reads off screen
      read_cell(5'd0, 6'd0);
      put_char(8'd65);
      put_char(8'd0);
      put_char(8'd255);
      put_char(8'd127);
      put_char(CH_BS);
      put_char(CH_CR);
      put_char(CH_BS);
      put_char(CH_NL);
      read_cell(5'd0, 6'd1);
      read_cell(5'd0, 6'd2);
      read_cell(5'd0, 6'd0);
      read_cell(5'd31, 6'd63);
      read_cell(5'd23, 6'd40);
      read_cell(5'd24, 6'd0);
      tick();
      clear_screen();
      wait_idle();

      // Directed: lit cursor with an unprintable glyph, put hides it
      write_reg(CSR_BLINK_PERIOD, 8'd1);
      write_reg(CSR_CURSOR_GLYPH, 8'd0);
      tick();
      read_cell(5'd0, 6'd0);
      read_cell(5'd0, 6'd1);
      tick();
      tick();
      put_char(8'd66);
      read_cell(5'd0, 6'd0);
      wait_idle();

      // Random phases, each with its own register setting and idling mix
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_BLINK_PERIOD, 8'd10);
               write_reg(CSR_CURSOR_GLYPH, 8'd64);
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               write_reg(CSR_BLINK_PERIOD, 8'd0);
               write_reg(CSR_CURSOR_GLYPH, 8'd127);
               send_idle_pct = 60;
               recv_stall_pct = 0;
            end
            2: begin
               write_reg(CSR_BLINK_PERIOD, 8'd1);
               write_reg(CSR_CURSOR_GLYPH, 8'h9f);
               send_idle_pct = 0;
               recv_stall_pct = 60;
            end
            3: begin
               write_reg(CSR_BLINK_PERIOD, 8'd255);
               write_reg(CSR_CURSOR_GLYPH, 8'd32);
               send_idle_pct = 38;
               recv_stall_pct = 38;
            end
            default: begin
               write_reg(CSR_BLINK_PERIOD, 8'($urandom_range(2, 20)));
               write_reg(CSR_CURSOR_GLYPH, 8'($urandom_range(255)));
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         phase_start = words_sent;
         paused = 1'b0;
         while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
            random_burst();
            // hold off mid-phase until the block has drained
            if (!paused && words_sent - phase_start >= RANDOM_WORDS / (2 * PHASES)) begin
               wait_idle();
               paused = 1'b1;
            end
         end
         wait_idle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
